// File: design/ucb_pkg.sv
`timescale 1ns / 1ps
package ucb_pkg;

  localparam int MAX_PAYLOAD_DEF = 16;
  // Wide enough for a run length at any MAX_PAYLOAD up to 127.
  localparam int CMD_LEN_W = 7;

  localparam logic [7:0] START_BYTE = 8'hF8;
  localparam logic [7:0] CMD_READ   = 8'hFA;
  localparam logic [7:0] CMD_WRITE  = 8'hFB;
  localparam logic [7:0] DUMMY_BYTE = 8'h00;

  localparam logic [1:0] CH_SPI  = 2'd0;
  localparam logic [1:0] CH_UART = 2'd1;
  localparam logic [1:0] CH_ERR  = 2'd2;

  localparam logic OP_UART = 1'b0;
  localparam logic OP_SPI  = 1'b1;

  localparam logic ERR_LENGTH  = 1'b0;
  localparam logic ERR_COMMAND = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } ucb_in_t;

  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] tx_byte;
    logic       error_code;
    logic       last;
  } ucb_out_t;

  typedef struct packed {
    logic [1:0]           channel;
    logic                 error_code;
    logic                 from_buf;
    logic [CMD_LEN_W-1:0] len;
  } ucb_cmd_t;

endpackage

// File: design/ucb_front.sv
`timescale 1ns / 1ps
module ucb_front #(
  parameter int MAX_PAYLOAD = ucb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  ucb_pkg::ucb_in_t    in_item,
  input  logic                q_full,
  output logic                q_push,
  output ucb_pkg::ucb_cmd_t   q_data,
  input  logic                buf_done,
  output logic                mem_we,
  output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] mem_waddr,
  output logic [7:0]          mem_wdata
);
  import ucb_pkg::*;

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [6:0] {
    ST_HUNT      = 7'b0000001,
    ST_CMD       = 7'b0000010,
    ST_LEN_WR    = 7'b0000100,
    ST_LEN_RD    = 7'b0001000,
    ST_LEN_BAD   = 7'b0010000,
    ST_PAYLOAD   = 7'b0100000,
    ST_READ_WAIT = 7'b1000000
  } ucb_state_t;

  ucb_state_t       state_r, state_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             buf_pend_r, buf_pend_nxt;
  logic [LEN_W-1:0] cnt_inc;
  logic             accept;
  logic             len_ok;

  assign in_full = q_full ||
                   (buf_pend_r && (state_r == ST_PAYLOAD || state_r == ST_READ_WAIT));
  assign accept  = in_push && !in_full;
  assign cnt_inc = cnt_r + 1'b1;
  assign len_ok  = (in_item.rx_byte != 8'd0) && (in_item.rx_byte <= 8'(MAX_PAYLOAD));

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    buf_pend_nxt = buf_pend_r && !buf_done;
    q_push       = 1'b0;
    q_data       = '0;
    mem_we       = 1'b0;
    mem_waddr    = cnt_r[AW-1:0];
    mem_wdata    = in_item.rx_byte;
    if (accept) begin
      if (in_item.op == OP_SPI) begin
        if (state_r == ST_READ_WAIT) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_inc;
          if (cnt_inc == len_r) begin
            q_push          = 1'b1;
            q_data.channel  = CH_UART;
            q_data.from_buf = 1'b1;
            q_data.len      = CMD_LEN_W'(len_r);
            state_nxt       = ST_HUNT;
            cnt_nxt         = '0;
            len_nxt         = '0;
            buf_pend_nxt    = 1'b1;
          end
        end
      end else begin
        unique case (state_r) inside
          ST_CMD: begin
            if (in_item.rx_byte == CMD_WRITE) begin
              state_nxt = ST_LEN_WR;
            end else if (in_item.rx_byte == CMD_READ) begin
              state_nxt = ST_LEN_RD;
            end else begin
              state_nxt = ST_LEN_BAD;
            end
          end
          ST_LEN_WR, ST_LEN_RD, ST_LEN_BAD: begin
            if (!len_ok || state_r == ST_LEN_BAD) begin
              q_push            = 1'b1;
              q_data.channel    = CH_ERR;
              q_data.error_code = len_ok ? ERR_COMMAND : ERR_LENGTH;
              q_data.len        = CMD_LEN_W'(1);
              state_nxt         = ST_HUNT;
            end else begin
              len_nxt = in_item.rx_byte[LEN_W-1:0];
              cnt_nxt = '0;
              if (state_r == ST_LEN_WR) begin
                state_nxt = ST_PAYLOAD;
              end else begin
                q_push     = 1'b1;
                q_data.channel = CH_SPI;
                q_data.len = CMD_LEN_W'(in_item.rx_byte[LEN_W-1:0]);
                state_nxt  = ST_READ_WAIT;
              end
            end
          end
          ST_PAYLOAD: begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_inc;
            if (cnt_inc == len_r) begin
              q_push          = 1'b1;
              q_data.channel  = CH_SPI;
              q_data.from_buf = 1'b1;
              q_data.len      = CMD_LEN_W'(len_r);
              state_nxt       = ST_HUNT;
              cnt_nxt         = '0;
              len_nxt         = '0;
              buf_pend_nxt    = 1'b1;
            end
          end
          ST_READ_WAIT: begin
            state_nxt = ST_READ_WAIT;
          end
          default: begin
            if (in_item.rx_byte == START_BYTE) begin
              state_nxt = ST_CMD;
              cnt_nxt   = '0;
            end else begin
              state_nxt = ST_HUNT;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_HUNT;
      cnt_r      <= '0;
      len_r      <= '0;
      buf_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      len_r      <= len_nxt;
      buf_pend_r <= buf_pend_nxt;
    end
  end

endmodule

// File: design/ucb_cmdq.sv
`timescale 1ns / 1ps
module ucb_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ucb_pkg::ucb_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output ucb_pkg::ucb_cmd_t head
);
  import ucb_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  ucb_cmd_t        ent_r [DEPTH];
  logic [PW-1:0]   wptr_r;
  logic [PW-1:0]   rptr_r;
  logic [CW-1:0]   cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_data;
    end
  end

endmodule

// File: design/ucb_back.sv
`timescale 1ns / 1ps
module ucb_back #(
  parameter int MAX_PAYLOAD = ucb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ucb_pkg::ucb_cmd_t   q_head,
  output logic                q_pop,
  output logic                buf_done,
  input  logic                mem_we,
  input  logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] mem_waddr,
  input  logic [7:0]          mem_wdata,
  output logic                out_empty,
  input  logic                out_pop,
  output ucb_pkg::ucb_out_t   out_item
);
  import ucb_pkg::*;

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]       mem_r [MAX_PAYLOAD];
  logic             active_r;
  ucb_cmd_t         cmd_r;
  logic [LEN_W-1:0] idx_r;
  logic             s1_v_r;
  logic [1:0]       s1_ch_r;
  logic             s1_ec_r;
  logic             s1_last_r;
  logic             s1_buf_r;
  logic [7:0]       rd_data_r;
  logic             out_v_r;
  ucb_out_t         out_r;

  logic             out_move;
  logic             issue;
  logic [LEN_W-1:0] idx_inc;
  logic             is_last;

  assign out_move  = s1_v_r && (!out_v_r || out_pop);
  assign issue     = active_r && (!s1_v_r || out_move);
  assign idx_inc   = idx_r + 1'b1;
  assign is_last   = (idx_inc == cmd_r.len[LEN_W-1:0]);
  assign q_pop     = !active_r && !q_empty;
  assign buf_done  = issue && is_last && cmd_r.from_buf;
  assign out_empty = !out_v_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= 1'b1;
      end else if (issue && is_last) begin
        active_r <= 1'b0;
      end
      if (issue) begin
        s1_v_r <= 1'b1;
      end else if (out_move) begin
        s1_v_r <= 1'b0;
      end
      if (out_move) begin
        out_v_r <= 1'b1;
      end else if (out_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
      idx_r <= '0;
    end else if (issue) begin
      idx_r <= idx_inc;
    end
    if (issue) begin
      rd_data_r <= mem_r[idx_r[AW-1:0]];
      s1_ch_r   <= cmd_r.channel;
      s1_ec_r   <= cmd_r.error_code;
      s1_last_r <= is_last;
      s1_buf_r  <= cmd_r.from_buf;
    end
    if (out_move) begin
      out_r.channel    <= s1_ch_r;
      out_r.tx_byte    <= s1_buf_r ? rd_data_r : DUMMY_BYTE;
      out_r.error_code <= s1_ec_r;
      out_r.last       <= s1_last_r;
    end
  end

endmodule

// File: design/uart_to_spi_command_bridge.sv
`timescale 1ns / 1ps
// Channel   Ports                          Moves
// input     in_push, in_full, in_item      one received byte and its source
// result    out_empty, out_pop, out_item   one byte or error report to transmit
//
// The front takes one request per cycle while it is not stalled and classifies it against the frame.
// A run of N results leaves the back one per cycle while out_pop takes them, passing through
// the command register, the buffer read stage and the output register; an error report is a run of one.
// The front stalls when the command queue is full, or while it gathers payload or
// SPI bytes and the back still reads the buffer for the previous run.
// Reset is synchronous; the payload buffer needs no clearing pass.
module uart_to_spi_command_bridge #(
  parameter int MAX_PAYLOAD = ucb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  ucb_pkg::ucb_in_t  in_item,
  output logic              out_empty,
  input  logic              out_pop,
  output ucb_pkg::ucb_out_t out_item
);
  import ucb_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  ucb_cmd_t      q_data;
  ucb_cmd_t      q_head;
  logic          buf_done;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  ucb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data),
    .buf_done  (buf_done),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  ucb_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  ucb_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .buf_done  (buf_done),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// File: dv/tb_uart_to_spi_command_bridge.sv
`timescale 1ns / 1ps
module tb_uart_to_spi_command_bridge;
  import ucb_pkg::*;

  localparam int MAX_PAYLOAD = MAX_PAYLOAD_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic [6:0] {
    FR_HUNT      = 7'b0000001,
    FR_CMD       = 7'b0000010,
    FR_LEN_WR    = 7'b0000100,
    FR_LEN_RD    = 7'b0001000,
    FR_LEN_BAD   = 7'b0010000,
    FR_PAYLOAD   = 7'b0100000,
    FR_READ_WAIT = 7'b1000000
  } frame_state_t;

  typedef struct packed {
    ucb_in_t  item;
    logic     typed;
    ucb_out_t want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_push = 1'b0;
  logic     in_full;
  ucb_in_t  in_item = '0;
  logic     out_empty;
  logic     out_pop = 1'b0;
  ucb_out_t out_item;

  frame_state_t fr_state = FR_HUNT;
  logic [4:0]   run_len = '0;
  logic [4:0]   got_cnt = '0;
  logic [7:0]   held_bytes [MAX_PAYLOAD];

  ucb_out_t  due_q [$];
  stim_row_t stim_q [$];

  int fails = 0;
  int cycles = 0;
  int send_idle = 0;
  int pop_stall = 0;
  int hold_left = 0;

  int send_idle_by_phase [4] = '{0, 86, 0, 21};
  int pop_stall_by_phase [4] = '{0, 0, 86, 21};

  uart_to_spi_command_bridge #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void queue_run(logic [1:0] ch, logic zeros);
    for (int i = 0; i < run_len; i++) begin
      due_q.push_back({ch, zeros ? DUMMY_BYTE : held_bytes[i], 1'b0, i == run_len - 1});
    end
  endfunction

  function automatic void bridge_predict(ucb_in_t it);
    if (it.op == OP_SPI) begin
      if (fr_state == FR_READ_WAIT) begin
        if (got_cnt < MAX_PAYLOAD) held_bytes[got_cnt] = it.rx_byte;
        got_cnt++;
        if (got_cnt >= run_len) begin
          queue_run(CH_UART, 1'b0);
          fr_state = FR_HUNT;
          got_cnt = '0;
          run_len = '0;
        end
      end
      return;
    end
    unique case (fr_state) inside
      FR_CMD: begin
        if (it.rx_byte == CMD_WRITE) fr_state = FR_LEN_WR;
        else if (it.rx_byte == CMD_READ) fr_state = FR_LEN_RD;
        else fr_state = FR_LEN_BAD;
      end
      FR_LEN_WR, FR_LEN_RD, FR_LEN_BAD: begin
        if (it.rx_byte == 8'h00 || it.rx_byte > MAX_PAYLOAD) begin
          due_q.push_back({CH_ERR, 8'h00, ERR_LENGTH, 1'b1});
          fr_state = FR_HUNT;
        end else if (fr_state == FR_LEN_BAD) begin
          due_q.push_back({CH_ERR, 8'h00, ERR_COMMAND, 1'b1});
          fr_state = FR_HUNT;
        end else begin
          run_len = it.rx_byte[4:0];
          got_cnt = '0;
          if (fr_state == FR_LEN_WR) begin
            fr_state = FR_PAYLOAD;
          end else begin
            fr_state = FR_READ_WAIT;
            queue_run(CH_SPI, 1'b1);
          end
        end
      end
      FR_PAYLOAD: begin
        if (got_cnt < MAX_PAYLOAD) held_bytes[got_cnt] = it.rx_byte;
        got_cnt++;
        if (got_cnt >= run_len) begin
          queue_run(CH_SPI, 1'b0);
          fr_state = FR_HUNT;
          got_cnt = '0;
          run_len = '0;
        end
      end
      FR_READ_WAIT: ;
      default: begin
        if (it.rx_byte == START_BYTE) begin
          fr_state = FR_CMD;
          got_cnt = '0;
        end else begin
          fr_state = FR_HUNT;
        end
      end
    endcase
  endfunction

  function automatic void add_row(logic op, logic [7:0] b, logic typed = 1'b0,
                                  ucb_out_t want = '0);
    stim_q.push_back({op, b, typed, want});
  endfunction

  // Mostly well-formed frames with random content, plus bad frames and noise.
  // Noise bytes are not counted against the budget since the block drops them.
  function automatic void queue_frames(int budget);
    int         kind;
    int         len;
    logic [7:0] b;
    while (budget > 0) begin
      kind = $urandom_range(99);
      len = $urandom_range(99);
      if (len < 70) len = $urandom_range(4, 1);
      else if (len < 90) len = $urandom_range(15, 5);
      else len = MAX_PAYLOAD;
      if (kind < 40) begin
        add_row(OP_UART, START_BYTE);
        add_row(OP_UART, CMD_WRITE);
        add_row(OP_UART, 8'(len));
        repeat (len) begin
          b = 8'($urandom_range(255));
          add_row(OP_UART, b);
        end
        budget -= len + 3;
      end else if (kind < 70) begin
        add_row(OP_UART, START_BYTE);
        add_row(OP_UART, CMD_READ);
        add_row(OP_UART, 8'(len));
        repeat (len) begin
          if ($urandom_range(9) == 0) begin
            b = 8'($urandom_range(255));
            add_row(OP_UART, b);
          end
          b = 8'($urandom_range(255));
          add_row(OP_SPI, b);
        end
        budget -= len + 3;
      end else if (kind < 80) begin
        add_row(OP_UART, START_BYTE);
        case ($urandom_range(2))
          0: b = CMD_WRITE;
          1: b = CMD_READ;
          default: b = 8'($urandom_range(255));
        endcase
        add_row(OP_UART, b);
        if ($urandom_range(1)) b = 8'h00;
        else b = 8'($urandom_range(255, MAX_PAYLOAD + 1));
        add_row(OP_UART, b);
        budget -= 3;
      end else if (kind < 90) begin
        add_row(OP_UART, START_BYTE);
        do b = 8'($urandom_range(255)); while (b == CMD_WRITE || b == CMD_READ);
        add_row(OP_UART, b);
        add_row(OP_UART, 8'(len));
        budget -= 3;
      end else begin
        repeat ($urandom_range(3, 1)) begin
          if ($urandom_range(1)) begin
            b = 8'($urandom_range(255));
            add_row(OP_SPI, b);
          end else begin
            do b = 8'($urandom_range(255)); while (b == START_BYTE);
            add_row(OP_UART, b);
          end
        end
      end
    end
  endfunction

  task automatic send_rows();
    stim_row_t row;
    while (stim_q.size() != 0) begin
      row = stim_q.pop_front();
      while ($urandom_range(99) < send_idle) begin
        in_push <= 1'b0;
        @(posedge clk);
      end
      in_item <= row.item;
      in_push <= 1'b1;
      do @(posedge clk); while (in_full);
      bridge_predict(row.item);
      if (row.typed) begin
        void'(due_q.pop_back());
        due_q.push_back(row.want);
      end
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : result_side
    ucb_out_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (due_q.size() == 0) begin
          $error("result with no request pending: channel %0d, tx_byte 0x%0h",
                 out_item.channel, out_item.tx_byte);
          fails++;
        end else begin
          want = due_q.pop_front();
          check_field("channel", want.channel, out_item.channel);
          check_field("tx_byte", want.tx_byte, out_item.tx_byte);
          check_field("error_code", want.error_code, out_item.error_code);
          check_field("last", want.last, out_item.last);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_stall);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(OP_SPI, 8'h55);
    add_row(OP_UART, 8'h00);
    add_row(OP_UART, START_BYTE);
    add_row(OP_UART, CMD_WRITE);
    add_row(OP_UART, 8'h00, 1'b1, {CH_ERR, 8'h00, ERR_LENGTH, 1'b1});
    add_row(OP_UART, START_BYTE);
    add_row(OP_UART, 8'h12);
    add_row(OP_UART, 8'h11, 1'b1, {CH_ERR, 8'h00, ERR_LENGTH, 1'b1});
    add_row(OP_UART, START_BYTE);
    add_row(OP_UART, START_BYTE);
    add_row(OP_UART, 8'h03, 1'b1, {CH_ERR, 8'h00, ERR_COMMAND, 1'b1});
    add_row(OP_UART, START_BYTE);
    add_row(OP_UART, 8'h00);
    add_row(OP_UART, 8'h10, 1'b1, {CH_ERR, 8'h00, ERR_COMMAND, 1'b1});
    add_row(OP_UART, START_BYTE);
    add_row(OP_UART, CMD_READ);
    add_row(OP_UART, 8'h01, 1'b1, {CH_SPI, DUMMY_BYTE, 1'b0, 1'b1});
    add_row(OP_UART, START_BYTE);
    add_row(OP_SPI, 8'hFF, 1'b1, {CH_UART, 8'hFF, 1'b0, 1'b1});
    add_row(OP_UART, START_BYTE);
    add_row(OP_UART, CMD_WRITE);
    add_row(OP_UART, 8'h02);
    add_row(OP_UART, START_BYTE);
    add_row(OP_UART, 8'h00);
    add_row(OP_UART, START_BYTE);
    add_row(OP_UART, 8'hFF);
    add_row(OP_UART, 8'hFF, 1'b1, {CH_ERR, 8'h00, ERR_LENGTH, 1'b1});
    send_rows();

    for (int p = 0; p < 4; p++) begin
      send_idle = send_idle_by_phase[p];
      pop_stall = pop_stall_by_phase[p];
      queue_frames(55);
      send_rows();
    end

    // Keep the result side closed while requests stream in back to back.
    send_idle = 0;
    pop_stall = 0;
    hold_left = 600;
    queue_frames(40);
    send_rows();
    in_push <= 1'b0;

    while (due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ucb_pkg.sv
design/ucb_front.sv
design/ucb_cmdq.sv
design/ucb_back.sv
design/uart_to_spi_command_bridge.sv
dv/tb_uart_to_spi_command_bridge.sv
